### hdl/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared widths, constants and month tables for the date difference core.
// ----------------------------------------------------------------------------
package ddc_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned YEARS_W  = 15;
  localparam int unsigned DAYS_W   = 23;
  localparam int unsigned CENT_W   = 8;   // width of year / 100
  localparam int unsigned MDAYS_W  = 10;  // days before month plus day

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  MIN_YEAR  = YEAR_W'(1);

  // floor(q / 25) == (q * RECIP_25) >> RECIP_SHIFT for every 12-bit q
  localparam int unsigned        QUART_W     = YEAR_W - 2;
  localparam logic [10:0]        RECIP_25    = 11'd1311;
  localparam int unsigned        RECIP_SHIFT = 15;
  localparam int unsigned        PROD_W      = QUART_W + 11;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0]   FEB_LEAP  = DAY_W'(29);
  localparam logic [8:0]         DAYS_YEAR = 9'd365;

  // Stage load enables shared by both date lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
      default:                   len = DAY_W'(31);
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### hdl/ddc_day_number.sv
// ----------------------------------------------------------------------------
// ddc_day_number
// Three-stage lane: normalizes one date and forms its day number.
// ----------------------------------------------------------------------------
module ddc_day_number (
  input  logic                         clk_i,
  input  ddc_pkg::stage_en_t           en_i,
  input  logic [ddc_pkg::YEAR_W-1:0]   year_i,
  input  logic [ddc_pkg::MONTH_W-1:0]  month_i,
  input  logic [ddc_pkg::DAY_W-1:0]    day_i,
  output logic [ddc_pkg::YEAR_W-1:0]   year_o,
  output logic [ddc_pkg::MONTH_W-1:0]  month_o,
  output logic [ddc_pkg::DAY_W-1:0]    day_o,
  output logic [ddc_pkg::DAYS_W-1:0]   day_num_o
);

  // Stage 1: clamp year, fix month, divide year and year-1 by 100
  logic [ddc_pkg::YEAR_W-1:0]  y_c, p_c;
  logic [ddc_pkg::MONTH_W-1:0] m_c;
  logic [ddc_pkg::PROD_W-1:0]  prod_y, prod_p;

  logic [ddc_pkg::YEAR_W-1:0]  y1_q, p1_q;
  logic [ddc_pkg::MONTH_W-1:0] m1_q;
  logic [ddc_pkg::DAY_W-1:0]   d1_q;
  logic [ddc_pkg::CENT_W-1:0]  cy1_q, cp1_q;

  always_comb begin
    if (year_i < ddc_pkg::MIN_YEAR) begin
      y_c = ddc_pkg::MIN_YEAR;
    end else if (year_i > ddc_pkg::MAX_YEAR) begin
      y_c = ddc_pkg::MAX_YEAR;
    end else begin
      y_c = year_i;
    end
    p_c = y_c - ddc_pkg::MIN_YEAR;
    if (month_i < ddc_pkg::MONTH_JAN || month_i > ddc_pkg::MONTH_DEC) begin
      m_c = ddc_pkg::MONTH_JAN;
    end else begin
      m_c = month_i;
    end
    prod_y = ddc_pkg::PROD_W'(y_c[ddc_pkg::YEAR_W-1:2]) * ddc_pkg::PROD_W'(ddc_pkg::RECIP_25);
    prod_p = ddc_pkg::PROD_W'(p_c[ddc_pkg::YEAR_W-1:2]) * ddc_pkg::PROD_W'(ddc_pkg::RECIP_25);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      y1_q  <= y_c;
      p1_q  <= p_c;
      m1_q  <= m_c;
      d1_q  <= day_i;
      cy1_q <= prod_y[ddc_pkg::RECIP_SHIFT +: ddc_pkg::CENT_W];
      cp1_q <= prod_p[ddc_pkg::RECIP_SHIFT +: ddc_pkg::CENT_W];
    end
  end

  // Stage 2: leap test, day fix, year base and in-year offset
  logic [ddc_pkg::YEAR_W-1:0]  cent_y;
  logic                        leap;
  logic [ddc_pkg::DAY_W-1:0]   len, d_fix;
  logic [ddc_pkg::DAYS_W-1:0]  base_d;
  logic [ddc_pkg::MDAYS_W-1:0] mdays_d;

  logic [ddc_pkg::YEAR_W-1:0]  y2_q;
  logic [ddc_pkg::MONTH_W-1:0] m2_q;
  logic [ddc_pkg::DAY_W-1:0]   d2_q;
  logic [ddc_pkg::DAYS_W-1:0]  base_q;
  logic [ddc_pkg::MDAYS_W-1:0] mdays_q;

  always_comb begin
    cent_y = (ddc_pkg::YEAR_W'(cy1_q) << 6) + (ddc_pkg::YEAR_W'(cy1_q) << 5)
           + (ddc_pkg::YEAR_W'(cy1_q) << 2);
    leap   = (y1_q[1:0] == 2'b00) && ((y1_q != cent_y) || (cy1_q[1:0] == 2'b00));
    len    = (leap && m1_q == ddc_pkg::MONTH_FEB) ? ddc_pkg::FEB_LEAP
                                                  : ddc_pkg::month_len(m1_q);
    d_fix  = (d1_q < ddc_pkg::DAY_FIRST || d1_q > len) ? ddc_pkg::DAY_FIRST : d1_q;
    base_d = ddc_pkg::DAYS_W'(p1_q) * ddc_pkg::DAYS_W'(ddc_pkg::DAYS_YEAR)
           + ddc_pkg::DAYS_W'(p1_q[ddc_pkg::YEAR_W-1:2])
           - ddc_pkg::DAYS_W'(cp1_q)
           + ddc_pkg::DAYS_W'(cp1_q[ddc_pkg::CENT_W-1:2]);
    mdays_d = ddc_pkg::MDAYS_W'(ddc_pkg::days_before(m1_q))
            + ddc_pkg::MDAYS_W'(leap && m1_q > ddc_pkg::MONTH_FEB)
            + ddc_pkg::MDAYS_W'(d_fix);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      y2_q    <= y1_q;
      m2_q    <= m1_q;
      d2_q    <= d_fix;
      base_q  <= base_d;
      mdays_q <= mdays_d;
    end
  end

  // Stage 3: day number
  logic [ddc_pkg::YEAR_W-1:0]  y3_q;
  logic [ddc_pkg::MONTH_W-1:0] m3_q;
  logic [ddc_pkg::DAY_W-1:0]   d3_q;
  logic [ddc_pkg::DAYS_W-1:0]  dn3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      y3_q  <= y2_q;
      m3_q  <= m2_q;
      d3_q  <= d2_q;
      dn3_q <= base_q + ddc_pkg::DAYS_W'(mdays_q);
    end
  end

  assign year_o    = y3_q;
  assign month_o   = m3_q;
  assign day_o     = d3_q;
  assign day_num_o = dn3_q;

endmodule

### hdl/date_difference_calculator_core.sv
// ----------------------------------------------------------------------------
// date_difference_calculator_core
// Normalizes two Gregorian dates, returns completed years and days between.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the stage 1, 2 and 3 registers and then the stage 4 output register.
// Throughput: one request per cycle while the output is not stalled; set by the
//   four-stage pipeline, each stage holding one request, with a per-stage valid bit.
// Reset: rst_ni clears every stage valid bit at once; payload is not reset.
// A stall on the output holds only the unbroken run of full stages behind it.
module date_difference_calculator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ddc_pkg::YEAR_W-1:0]          birth_year_i,
  input  logic [ddc_pkg::MONTH_W-1:0]         birth_month_i,
  input  logic [ddc_pkg::DAY_W-1:0]           birth_day_i,
  input  logic [ddc_pkg::YEAR_W-1:0]          now_year_i,
  input  logic [ddc_pkg::MONTH_W-1:0]         now_month_i,
  input  logic [ddc_pkg::DAY_W-1:0]           now_day_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ddc_pkg::MONTH_W-1:0]         birth_month_fixed_o,
  output logic [ddc_pkg::DAY_W-1:0]           birth_day_fixed_o,
  output logic [ddc_pkg::MONTH_W-1:0]         now_month_fixed_o,
  output logic [ddc_pkg::DAY_W-1:0]           now_day_fixed_o,
  output logic signed [ddc_pkg::YEARS_W-1:0]  whole_years_o,
  output logic signed [ddc_pkg::DAYS_W-1:0]   day_count_o
);

  // Stage valid bits; stage 4 is the output register
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  ddc_pkg::stage_en_t en;

  // A stage loads when it is empty or its contents move on this cycle
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Two identical lanes, one per date, stepping in lock-step
  logic [ddc_pkg::YEAR_W-1:0]  b_year, n_year;
  logic [ddc_pkg::MONTH_W-1:0] b_month, n_month;
  logic [ddc_pkg::DAY_W-1:0]   b_day, n_day;
  logic [ddc_pkg::DAYS_W-1:0]  b_num, n_num;

  ddc_day_number u_birth (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (birth_year_i),
    .month_i   (birth_month_i),
    .day_i     (birth_day_i),
    .year_o    (b_year),
    .month_o   (b_month),
    .day_o     (b_day),
    .day_num_o (b_num)
  );

  ddc_day_number u_now (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (now_year_i),
    .month_i   (now_month_i),
    .day_i     (now_day_i),
    .year_o    (n_year),
    .month_o   (n_month),
    .day_o     (n_day),
    .day_num_o (n_num)
  );

  // Stage 4: year difference, less one when the anniversary is not yet reached, and day difference
  logic                               before_anniv;
  logic [ddc_pkg::YEARS_W-1:0]        years_d;
  logic [ddc_pkg::DAYS_W-1:0]         days_d;

  logic [ddc_pkg::MONTH_W-1:0]        bm4_q, nm4_q;
  logic [ddc_pkg::DAY_W-1:0]          bd4_q, nd4_q;
  logic [ddc_pkg::YEARS_W-1:0]        years_q;
  logic [ddc_pkg::DAYS_W-1:0]         days_q;

  always_comb begin
    before_anniv = (n_month < b_month) || ((n_month == b_month) && (n_day < b_day));
    years_d = ddc_pkg::YEARS_W'(n_year) - ddc_pkg::YEARS_W'(b_year)
            - ddc_pkg::YEARS_W'(before_anniv);
    days_d  = n_num - b_num;
  end

  // Hold the result while the output is stalled
  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      bm4_q   <= b_month;
      bd4_q   <= b_day;
      nm4_q   <= n_month;
      nd4_q   <= n_day;
      years_q <= years_d;
      days_q  <= days_d;
    end
  end

  assign out_valid_o         = v4_q;
  assign birth_month_fixed_o = bm4_q;
  assign birth_day_fixed_o   = bd4_q;
  assign now_month_fixed_o   = nm4_q;
  assign now_day_fixed_o     = nd4_q;
  assign whole_years_o       = years_q;
  assign day_count_o         = days_q;

endmodule

### hdl/ddc_checker.sv
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks on the date difference core, bound to the top level.
// ----------------------------------------------------------------------------
module ddc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [ddc_pkg::MONTH_W-1:0]         birth_month_fixed_o,
  input  logic signed [ddc_pkg::YEARS_W-1:0]  whole_years_o,
  input  logic signed [ddc_pkg::DAYS_W-1:0]   day_count_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A request accepted while the output path stays free reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

  // Completed years agree in sign with the day difference; the fixed birth month is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (day_count_o < 0) |-> (whole_years_o < 0))
    else $error("negative day count with non-negative years");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (day_count_o >= 0) |->
      (whole_years_o >= 0) && (birth_month_fixed_o != '0))
    else $error("non-negative day count with negative years or bad month");

endmodule

bind date_difference_calculator_core ddc_checker u_ddc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .birth_month_fixed_o (birth_month_fixed_o),
  .whole_years_o       (whole_years_o),
  .day_count_o         (day_count_o)
);
